FILE: rtl/i2c_bit_level_master_core_assert.svh
// Assertion macros shared by the I2C bit-level master RTL.
`ifndef I2C_BIT_LEVEL_MASTER_CORE_ASSERT_SVH
`define I2C_BIT_LEVEL_MASTER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define I2CBM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define I2CBM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/i2cbm_pkg.sv
// Types and constants for the I2C bit-level master core.
package i2cbm_pkg;

    // Command codes carried in the input tuser field.
    localparam logic [2:0] ACT_NONE      = 3'd0;
    localparam logic [2:0] ACT_START     = 3'd1;
    localparam logic [2:0] ACT_STOP      = 3'd2;
    localparam logic [2:0] ACT_WRITE     = 3'd3;
    localparam logic [2:0] ACT_READ_ACK  = 3'd4;
    localparam logic [2:0] ACT_READ_NACK = 3'd5;

    // Configuration register indexes.
    localparam logic [1:0] CFG_HALF_PERIOD = 2'd0;
    localparam logic [1:0] CFG_POST_UNITS  = 2'd1;
    localparam logic [1:0] CFG_POLL_LIMIT  = 2'd2;

    // Register reset values.
    localparam logic [15:0] HALF_PERIOD_RST = 16'd50;
    localparam logic [7:0]  POST_UNITS_RST  = 8'd10;
    localparam logic [15:0] POLL_LIMIT_RST  = 16'd499;

    // Bits per transferred byte.
    localparam logic [3:0] BYTE_BITS = 4'd8;

    // Bus sequencer phases, one-hot.
    typedef enum logic [14:0] {
        PH_IDLE       = 15'b000000000000001,
        PH_START_A    = 15'b000000000000010,
        PH_START_B    = 15'b000000000000100,
        PH_STOP       = 15'b000000000001000,
        PH_WR_LOW     = 15'b000000000010000,
        PH_WR_HIGH    = 15'b000000000100000,
        PH_WR_POST    = 15'b000000001000000,
        PH_WR_POLL    = 15'b000000010000000,
        PH_WR_ACK     = 15'b000000100000000,
        PH_RD_LOW     = 15'b000001000000000,
        PH_RD_HIGH    = 15'b000010000000000,
        PH_RD_TAIL    = 15'b000100000000000,
        PH_RD_ACK_LOW = 15'b001000000000000,
        PH_RD_ACK_HI  = 15'b010000000000000,
        PH_RD_NACK    = 15'b100000000000000
    } t_phase;

endpackage

FILE: rtl/i2c_bit_level_master_core.sv
// I2C bit-level bus master: one tick per input transfer, one result per tick.
//
//  Channel   Direction  Payload
//  s_axis    in         tuser: action[2:0]; tdata: send_byte[7:0], sda_sample[8]
//  m_axis    out        tdata: scl, sda, busy, done, received_byte[11:4], ack_missing[12]
//  cfg       in         i_cfg_we, i_cfg_index[1:0], i_cfg_wdata[15:0]
//
// For each tick, the sequencer state and the result register update in the cycle
// the input transfer is accepted.
// The result register decouples the sides; a new tick is accepted whenever the
// result register is empty or its result is taken in the same cycle.
// Reset (i_rst_n low, synchronous) idles the sequencer, releases SCL and SDA high
// and loads the configuration defaults.
`include "i2c_bit_level_master_core_assert.svh"

module i2c_bit_level_master_core
    import i2cbm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input ticks
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // send_byte[7:0], sda_sample[8], zero fill
    input  logic [2:0]  s_axis_tuser,   // action[2:0]
    // Results
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // scl[0], sda[1], busy[2], done[3],
                                        // received_byte[11:4], ack_missing[12], zero fill
    // Configuration writes
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_wdata
);

    // Configuration registers.
    logic [15:0] r_half_period;
    logic [7:0]  r_post_units;
    logic [15:0] r_poll_limit;

    // Sequencer state.
    t_phase      r_phase,  n_phase;
    logic [3:0]  r_bit_cnt, n_bit_cnt;
    logic [15:0] r_delay,  n_delay;
    logic [7:0]  r_units,  n_units;
    logic [7:0]  r_shift,  n_shift;
    logic [15:0] r_poll,   n_poll;
    logic        r_scl,    n_scl;
    logic        r_sda,    n_sda;
    logic        r_nack,   n_nack;
    logic [7:0]  r_rx,     n_rx;
    logic        r_rd_nack, n_rd_nack;

    // Result register.
    logic        r_m_valid;
    logic [15:0] r_m_data;

    logic        in_xfer;
    logic [2:0]  action;
    logic [7:0]  send_byte;
    logic        sda_sample;
    logic [15:0] half_eff;
    logic        done_now;
    logic        wait_end;
    logic [15:0] delay_inc;

    assign action     = s_axis_tuser;
    assign send_byte  = s_axis_tdata[7:0];
    assign sda_sample = s_axis_tdata[8];

    assign s_axis_tready = !r_m_valid || m_axis_tready;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    // A zero half period acts as one tick.
    assign half_eff  = (r_half_period == 16'd0) ? 16'd1 : r_half_period;
    assign delay_inc = r_delay + 16'd1;

    // Next sequencer state for one tick.
    always_comb begin
        n_phase   = r_phase;
        n_bit_cnt = r_bit_cnt;
        n_delay   = r_delay;
        n_units   = r_units;
        n_shift   = r_shift;
        n_poll    = r_poll;
        n_scl     = r_scl;
        n_sda     = r_sda;
        n_nack    = r_nack;
        n_rx      = r_rx;
        n_rd_nack = r_rd_nack;
        done_now  = 1'b0;
        wait_end  = 1'b0;

        if (r_phase == PH_IDLE) begin
            case (action)
                ACT_START: begin
                    n_sda   = 1'b1;
                    n_scl   = 1'b1;
                    n_phase = PH_START_A;
                    n_delay = 16'd0;
                    n_units = 8'd1;
                end
                ACT_STOP: begin
                    n_sda   = 1'b0;
                    n_scl   = 1'b1;
                    n_phase = PH_STOP;
                    n_delay = 16'd0;
                    n_units = 8'd1;
                end
                ACT_WRITE: begin
                    // Load the byte and put out its first bit at once.
                    n_nack    = 1'b0;
                    n_scl     = 1'b0;
                    n_sda     = send_byte[7];
                    n_shift   = {send_byte[6:0], 1'b0};
                    n_bit_cnt = BYTE_BITS - 4'd1;
                    n_phase   = PH_WR_LOW;
                    n_delay   = 16'd0;
                    n_units   = 8'd1;
                end
                ACT_READ_ACK, ACT_READ_NACK: begin
                    n_rd_nack = (action == ACT_READ_NACK);
                    n_sda     = 1'b1;
                    n_scl     = 1'b0;
                    n_shift   = 8'd0;
                    n_bit_cnt = BYTE_BITS - 4'd1;
                    n_phase   = PH_RD_LOW;
                    n_delay   = 16'd0;
                    n_units   = 8'd1;
                end
                default: begin
                end
            endcase
        end else if (r_phase == PH_WR_POLL) begin
            // A low sample is the acknowledge; high samples count toward the limit.
            if (!sda_sample) begin
                n_phase = PH_WR_ACK;
                n_delay = 16'd0;
                n_units = 8'd1;
            end else begin
                n_poll = r_poll + 16'd1;
                if (n_poll >= r_poll_limit) begin
                    n_nack  = 1'b1;
                    n_phase = PH_WR_ACK;
                    n_delay = 16'd0;
                    n_units = 8'd1;
                end
            end
        end else if (r_units == 8'd0) begin
            wait_end = 1'b1;
        end else begin
            n_delay = delay_inc;
            if (delay_inc >= half_eff) begin
                n_delay = 16'd0;
                n_units = r_units - 8'd1;
                wait_end = (n_units == 8'd0);
            end
        end

        // Step taken when a delay runs out.
        if (wait_end) begin
            case (r_phase)
                PH_START_A: begin
                    n_sda   = 1'b0;
                    n_phase = PH_START_B;
                    n_delay = 16'd0;
                    n_units = 8'd1;
                end
                PH_START_B: begin
                    n_scl    = 1'b0;
                    n_phase  = PH_IDLE;
                    done_now = 1'b1;
                end
                PH_STOP: begin
                    n_sda    = 1'b1;
                    n_phase  = PH_IDLE;
                    done_now = 1'b1;
                end
                PH_WR_LOW: begin
                    n_scl   = 1'b1;
                    n_phase = PH_WR_HIGH;
                    n_delay = 16'd0;
                    n_units = 8'd1;
                end
                PH_WR_HIGH: begin
                    if (r_bit_cnt != 4'd0) begin
                        n_scl     = 1'b0;
                        n_sda     = r_shift[7];
                        n_shift   = {r_shift[6:0], 1'b0};
                        n_bit_cnt = r_bit_cnt - 4'd1;
                        n_phase   = PH_WR_LOW;
                        n_delay   = 16'd0;
                        n_units   = 8'd1;
                    end else begin
                        // Release SDA for the slave; wait or go straight to polling.
                        n_scl = 1'b0;
                        n_sda = 1'b1;
                        if (r_post_units == 8'd0) begin
                            n_scl   = 1'b1;
                            n_poll  = 16'd0;
                            n_phase = PH_WR_POLL;
                        end else begin
                            n_phase = PH_WR_POST;
                            n_delay = 16'd0;
                            n_units = r_post_units;
                        end
                    end
                end
                PH_WR_POST: begin
                    n_scl   = 1'b1;
                    n_poll  = 16'd0;
                    n_phase = PH_WR_POLL;
                end
                PH_WR_ACK: begin
                    n_scl    = 1'b0;
                    n_phase  = PH_IDLE;
                    done_now = 1'b1;
                end
                PH_RD_LOW: begin
                    n_scl   = 1'b1;
                    n_phase = PH_RD_HIGH;
                    n_delay = 16'd0;
                    n_units = 8'd1;
                end
                PH_RD_HIGH: begin
                    // Sample SDA at the end of the high half period.
                    if (r_bit_cnt != 4'd0) begin
                        n_shift   = {r_shift[6:0] | {6'd0, sda_sample}, 1'b0};
                        n_scl     = 1'b0;
                        n_bit_cnt = r_bit_cnt - 4'd1;
                        n_phase   = PH_RD_LOW;
                    end else begin
                        n_shift = r_shift | {7'd0, sda_sample};
                        n_rx    = r_shift | {7'd0, sda_sample};
                        n_scl   = 1'b0;
                        n_phase = PH_RD_TAIL;
                    end
                    n_delay = 16'd0;
                    n_units = 8'd1;
                end
                PH_RD_TAIL: begin
                    if (r_rd_nack) begin
                        n_sda   = 1'b1;
                        n_scl   = 1'b1;
                        n_phase = PH_RD_NACK;
                    end else begin
                        n_sda   = 1'b0;
                        n_phase = PH_RD_ACK_LOW;
                    end
                    n_delay = 16'd0;
                    n_units = 8'd1;
                end
                PH_RD_ACK_LOW: begin
                    n_scl   = 1'b1;
                    n_phase = PH_RD_ACK_HI;
                    n_delay = 16'd0;
                    n_units = 8'd1;
                end
                PH_RD_ACK_HI, PH_RD_NACK: begin
                    n_scl    = 1'b0;
                    n_phase  = PH_IDLE;
                    done_now = 1'b1;
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_period <= HALF_PERIOD_RST;
            r_post_units  <= POST_UNITS_RST;
            r_poll_limit  <= POLL_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_HALF_PERIOD: r_half_period <= i_cfg_wdata;
                CFG_POST_UNITS:  r_post_units  <= i_cfg_wdata[7:0];
                CFG_POLL_LIMIT:  r_poll_limit  <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Sequencer state advances once per accepted tick.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_bit_cnt <= 4'd0;
            r_delay   <= 16'd0;
            r_units   <= 8'd0;
            r_shift   <= 8'd0;
            r_poll    <= 16'd0;
            r_scl     <= 1'b1;
            r_sda     <= 1'b1;
            r_nack    <= 1'b0;
            r_rx      <= 8'd0;
            r_rd_nack <= 1'b0;
        end else if (in_xfer) begin
            r_phase   <= n_phase;
            r_bit_cnt <= n_bit_cnt;
            r_delay   <= n_delay;
            r_units   <= n_units;
            r_shift   <= n_shift;
            r_poll    <= n_poll;
            r_scl     <= n_scl;
            r_sda     <= n_sda;
            r_nack    <= n_nack;
            r_rx      <= n_rx;
            r_rd_nack <= n_rd_nack;
        end
    end

    // Result register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (in_xfer) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    // Result payload, packed from the lowest bit up.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_m_data <= {3'd0, n_nack, n_rx, done_now, (n_phase != PH_IDLE), n_sda, n_scl};
        end
    end

    `I2CBM_ASSERT_NOW(a_no_accept_on_stall, i_clk, i_rst_n,
        r_m_valid && !m_axis_tready, !s_axis_tready,
        "input accepted while a result is stalled")

    `I2CBM_ASSERT_NEXT(a_result_follows_tick, i_clk, i_rst_n,
        in_xfer, r_m_valid,
        "accepted tick did not produce a result")

    `I2CBM_ASSERT_NOW(a_done_not_busy, i_clk, i_rst_n,
        r_m_valid && r_m_data[3], !r_m_data[2],
        "result reports done and busy together")

    `I2CBM_ASSERT_NOW(a_poll_scl_high, i_clk, i_rst_n,
        r_phase == PH_WR_POLL, r_scl && r_sda,
        "SCL or SDA not released while polling for acknowledge")

endmodule
